@@ src/pclu_pkg.sv @@
// ----------------------------------------------------------------------------
// pclu_pkg
// shared types and constants of the priority ceiling lock unit
// ----------------------------------------------------------------------------
package pclu_pkg;

  localparam int unsigned IdxWidth  = 4;
  localparam int unsigned TidWidth  = 8;
  localparam int unsigned PrioWidth = 8;
  localparam int unsigned CntWidth  = 8;

  localparam logic signed [PrioWidth-1:0] NoCeiling = 8'sd127;
  localparam logic [CntWidth-1:0]         CountMax  = 8'd255;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_DECLARE = 2'd1,
    FUNC_LOCK    = 2'd2,
    FUNC_UNLOCK  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BUSY       = 2'd1,
    ST_NOT_OWNER  = 2'd2,
    ST_NOT_LOCKED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_SCAN = 2'd2,
    S_RESP = 2'd3
  } state_e;

endpackage

@@ src/priority_ceiling_lock_unit.sv @@
// ----------------------------------------------------------------------------
// priority_ceiling_lock_unit
// immediate priority ceiling lock manager over a small resource table
// ----------------------------------------------------------------------------
// clear, declare, lock and failed unlock pass from accept through the execute and response steps to the result register
// owner unlock adds a scan step over min(NUM_RESOURCES, 16) table entries, one table entry per scan cycle
// a new transaction is accepted only in the idle step, after the previous one has left the response step
// a held result register stalls the response step, and the input with it
// rst_ni sets all ceilings and the system ceiling to 127, owners and hold counts to zero

module priority_ceiling_lock_unit
  import pclu_pkg::*;
#(
  parameter int unsigned NUM_RESOURCES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // resource_index [3:0], thread_id [11:4], priority_req [19:12], zero [23:20]
  input  logic [23:0] s_axis_tdata,
  // func [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status [1:0], thread_priority [9:2], system_ceiling_out [17:10], zero [23:18]
  output logic [23:0] m_axis_tdata
);

  localparam int unsigned Depth = (NUM_RESOURCES < 16) ? NUM_RESOURCES : 16;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  state_e state_q, state_d;

  logic signed [PrioWidth-1:0] ceil_q  [Depth];
  logic signed [PrioWidth-1:0] ceil_d  [Depth];
  logic [TidWidth-1:0]         owner_q [Depth];
  logic [TidWidth-1:0]         owner_d [Depth];
  logic [CntWidth-1:0]         cnt_q   [Depth];
  logic [CntWidth-1:0]         cnt_d   [Depth];
  logic signed [PrioWidth-1:0] sys_q, sys_d;

  func_e                       func_q, func_d;
  logic [IdxWidth-1:0]         idx_q, idx_d;
  logic [TidWidth-1:0]         tid_q, tid_d;
  logic signed [PrioWidth-1:0] prio_q, prio_d;

  logic [AW-1:0]               scan_q, scan_d;
  logic signed [PrioWidth-1:0] acc_sys_q, acc_sys_d;
  logic signed [PrioWidth-1:0] acc_tp_q, acc_tp_d;
  status_e                     res_st_q, res_st_d;

  logic                        out_vld_q, out_vld_d;
  status_e                     out_st_q, out_st_d;
  logic signed [PrioWidth-1:0] out_tp_q, out_tp_d;
  logic signed [PrioWidth-1:0] out_sys_q, out_sys_d;

  logic                        in_fire;
  logic                        out_free;
  logic                        idx_ok;
  logic [AW-1:0]               rd_addr;
  logic signed [PrioWidth-1:0] rd_ceil;
  logic [TidWidth-1:0]         rd_owner;
  logic [CntWidth-1:0]         rd_cnt;
  logic                        scan_last;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign idx_ok        = (9'(idx_q) < 9'(NUM_RESOURCES));
  assign scan_last     = (scan_q == AW'(Depth - 1));

  // single table read port, shared by the operation step and the scan
  assign rd_addr  = (state_q == S_SCAN) ? scan_q : AW'(idx_q);
  assign rd_ceil  = ceil_q[rd_addr];
  assign rd_owner = owner_q[rd_addr];
  assign rd_cnt   = cnt_q[rd_addr];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (func_q == FUNC_UNLOCK && idx_ok && rd_cnt != '0 && rd_owner == tid_q) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_RESP;
        end
      end
      S_SCAN: begin
        if (scan_last) state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ceil_d    = ceil_q;
    owner_d   = owner_q;
    cnt_d     = cnt_q;
    sys_d     = sys_q;
    func_d    = func_q;
    idx_d     = idx_q;
    tid_d     = tid_q;
    prio_d    = prio_q;
    scan_d    = scan_q;
    acc_sys_d = acc_sys_q;
    acc_tp_d  = acc_tp_q;
    res_st_d  = res_st_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    out_st_d  = out_st_q;
    out_tp_d  = out_tp_q;
    out_sys_d = out_sys_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          func_d = func_e'(s_axis_tuser);
          idx_d  = s_axis_tdata[3:0];
          tid_d  = s_axis_tdata[11:4];
          prio_d = s_axis_tdata[19:12];
        end
      end
      S_EXEC: begin
        res_st_d = ST_OK;
        acc_tp_d = prio_q;
        case (func_q)
          FUNC_CLEAR: begin
            for (int i = 0; i < Depth; i++) ceil_d[i] = NoCeiling;
            sys_d = NoCeiling;
          end
          FUNC_DECLARE: begin
            if (idx_ok && prio_q < rd_ceil) ceil_d[rd_addr] = prio_q;
          end
          FUNC_LOCK: begin
            if (!idx_ok) begin
              res_st_d = ST_NOT_LOCKED;
            end else if (rd_cnt != '0 && rd_owner != tid_q) begin
              res_st_d = ST_BUSY;
            end else begin
              if (rd_ceil < prio_q) acc_tp_d = rd_ceil;
              if (rd_ceil < sys_q) sys_d = rd_ceil;
              owner_d[rd_addr] = tid_q;
              if (rd_cnt != CountMax) cnt_d[rd_addr] = rd_cnt + CntWidth'(1);
            end
          end
          FUNC_UNLOCK: begin
            if (!idx_ok || rd_cnt == '0) begin
              res_st_d = ST_NOT_LOCKED;
            end else if (rd_owner != tid_q) begin
              res_st_d = ST_NOT_OWNER;
            end else begin
              cnt_d[rd_addr] = rd_cnt - CntWidth'(1);
              scan_d         = '0;
              acc_sys_d      = NoCeiling;
            end
          end
          default: res_st_d = ST_OK;
        endcase
      end
      S_SCAN: begin
        if (rd_cnt != '0) begin
          if (rd_ceil < acc_sys_q) acc_sys_d = rd_ceil;
          if (rd_owner == tid_q && rd_ceil < acc_tp_q) acc_tp_d = rd_ceil;
        end
        scan_d = scan_q + AW'(1);
        if (scan_last) begin
          scan_d = '0;
          sys_d  = (rd_cnt != '0 && rd_ceil < acc_sys_q) ? rd_ceil : acc_sys_q;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_st_d  = res_st_q;
          out_tp_d  = acc_tp_q;
          out_sys_d = sys_q;
        end
      end
      default: out_vld_d = out_vld_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      scan_q    <= '0;
      sys_q     <= NoCeiling;
      for (int i = 0; i < Depth; i++) begin
        ceil_q[i]  <= NoCeiling;
        owner_q[i] <= '0;
        cnt_q[i]   <= '0;
      end
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      scan_q    <= scan_d;
      sys_q     <= sys_d;
      ceil_q    <= ceil_d;
      owner_q   <= owner_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    idx_q     <= idx_d;
    tid_q     <= tid_d;
    prio_q    <= prio_d;
    acc_sys_q <= acc_sys_d;
    acc_tp_q  <= acc_tp_d;
    res_st_q  <= res_st_d;
    out_st_q  <= out_st_d;
    out_tp_q  <= out_tp_d;
    out_sys_q <= out_sys_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_sys_q, out_tp_q, out_st_q};

`ifndef ASSERT_OFF
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_EXEC)
    else $error("accepted transaction did not start execution");

  a_scan_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && $past(state_q) == S_EXEC) |-> scan_q == '0)
    else $error("scan did not start at entry zero");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == S_RESP)
    else $error("result loaded outside response step");
`endif

endmodule
